/* hw/rtl/ntdp_pkg.sv */
// ============================================================================
// ntdp_pkg
// Shared types, constants and helpers of the neighbor table with distance
// pruning: table geometry, item codes, the stored record and write command.
// ============================================================================
`default_nettype none

package ntdp_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 32;
    localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TBL_CW        = $clog2(TABLE_ENTRIES + 1);
    localparam logic [TBL_CW-1:0] TBL_N = TBL_CW'(TABLE_ENTRIES);

    // Field widths.
    localparam int ID_W   = 16;
    localparam int SPD_W  = 16;
    localparam int POS_W  = 32;
    localparam int TIM_W  = 32;
    localparam int DIST_W = 48;
    localparam int CNT_W  = 6;

    // Stream and configuration port widths.
    localparam int S_DATA_W = 240;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 64;
    localparam int CFG_IW   = 8;
    localparam int CFG_DW   = 32;

    // Item codes carried in tuser.
    localparam logic [1:0] FN_HELLO  = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_PRUNE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_OWN_SPEED = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_OWN_TS    = 8'd1;

    // One neighbor record as held in the table memory.
    typedef struct packed {
        logic [SPD_W-1:0]  own_speed;
        logic [DIST_W-1:0] distance;
        logic [POS_W-1:0]  dst_y;
        logic [POS_W-1:0]  dst_x;
        logic [POS_W-1:0]  src_y;
        logic [POS_W-1:0]  src_x;
        logic [SPD_W-1:0]  speed;
        logic [ID_W-1:0]   node;
    } t_rec;

    // Write command from the sequencer to the table memory.
    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        t_rec              rec;
    } t_tbl_wr;

    // Low six bits of a table count, zero-extended when the count is narrower.
    function automatic logic [CNT_W-1:0] cnt_to_out(input logic [TBL_CW-1:0] c);
        logic [TBL_CW+CNT_W-1:0] w;
        w = {{CNT_W{1'b0}}, c};
        return w[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ntdp_mul.sv */
// ============================================================================
// ntdp_mul
// Shared 16 x 32 bit unsigned multiplier with a registered 48-bit product.
// ============================================================================
`default_nettype none

module ntdp_mul (
    input  wire logic                        i_clk,
    input  wire logic [ntdp_pkg::SPD_W-1:0]  i_a,
    input  wire logic [ntdp_pkg::TIM_W-1:0]  i_b,
    output logic      [ntdp_pkg::DIST_W-1:0] o_p
);
    import ntdp_pkg::*;

    logic [DIST_W-1:0] r_p;

    // The product is exact in 48 bits; one register after the multiply.
    always_ff @(posedge i_clk) begin
        r_p <= DIST_W'(i_a) * DIST_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* hw/rtl/ntdp_table.sv */
// ============================================================================
// ntdp_table
// Record memory of the neighbor table: one write port, one read port with
// registered read data.
// ============================================================================
`default_nettype none

module ntdp_table (
    input  wire logic                        i_clk,
    input  wire ntdp_pkg::t_tbl_wr           i_wr,
    input  wire logic [ntdp_pkg::TBL_AW-1:0] i_rd_addr,
    output ntdp_pkg::t_rec                   o_rd_data
);
    import ntdp_pkg::*;

    t_rec r_mem [TABLE_ENTRIES];
    t_rec r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.rec;
        end
    end

    // Read port; the read data is registered and valid in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/neighbor_table_distance_prune_unit.sv */
// ============================================================================
// neighbor_table_distance_prune_unit
// Bounded neighbor table keyed by node id: hello insert/update, remove by id
// and prune by distance, run by a small sequencer over one record memory.
// ============================================================================
// Items enter on the slave stream (tuser: item code; tdata: id, speed,
// coordinates, time, prune limit). Each item transfer yields one result
// transfer on the master stream. The configuration channel writes own speed
// (index 0) and own timestamp (index 1); it is always ready. The user must
// write it only while the block idles; the block itself does not enforce it.
// From the item transfer to a valid result the sequencer runs two products
// on the shared multiplier and the difference, one slot per cycle through the
// memory read port, then a write-back state and the output register. The
// input is ready again in the cycle after the result is loaded; a new item is
// not taken until the last one has left the sequencer.
// Reset empties the table and clears both configuration registers. A stalled
// result waits in the output register; the next item may still be taken and
// holds its own result until that register is free.
// ============================================================================
`default_nettype none

module neighbor_table_distance_prune_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Item input stream.
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata from bit 0: node_id[15:0], speed[31:16], src_x[63:32],
    // src_y[95:64], dst_x[127:96], dst_y[159:128], now_time[191:160],
    // prune_limit[239:192]
    input  wire logic [ntdp_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // tuser from bit 0: func[1:0]
    input  wire logic [ntdp_pkg::S_USER_W-1:0] i_s_axis_tuser,
    // Result output stream.
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // tdata from bit 0: found[0], dropped[1], removed_count[7:2],
    // entry_count[13:8], distance[61:14], zero[63:62]
    output logic      [ntdp_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // Configuration write channel.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ntdp_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [ntdp_pkg::CFG_DW-1:0]   i_cfg_data
);
    import ntdp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_A = 3'd1;
    localparam logic [2:0] ST_MUL_B = 3'd2;
    localparam logic [2:0] ST_DIST  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Control state.
    logic [2:0]               r_state;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TBL_CW-1:0]        r_count;
    logic [TBL_CW-1:0]        r_removed;
    logic [TBL_CW-1:0]        r_cnt;
    logic                     r_chk;
    logic                     r_hit;
    logic                     r_have_free;
    logic                     r_m_valid;
    logic [SPD_W-1:0]         r_own_speed;
    logic [TIM_W-1:0]         r_own_ts;

    // Item payload and working registers.
    logic [1:0]               r_func;
    logic [ID_W-1:0]          r_node;
    logic [SPD_W-1:0]         r_speed;
    logic [POS_W-1:0]         r_src_x;
    logic [POS_W-1:0]         r_src_y;
    logic [POS_W-1:0]         r_dst_x;
    logic [POS_W-1:0]         r_dst_y;
    logic [TIM_W-1:0]         r_now;
    logic [DIST_W-1:0]        r_limit;
    logic [DIST_W-1:0]        r_prod_a;
    logic [DIST_W-1:0]        r_dist;
    logic [TBL_AW-1:0]        r_chk_idx;
    logic [TBL_AW-1:0]        r_hit_idx;
    logic [TBL_AW-1:0]        r_free_idx;
    logic                     r_found;
    logic                     r_dropped;
    logic [M_DATA_W-1:0]      r_m_data;

    // Datapath signals.
    logic [SPD_W-1:0]  mul_a;
    logic [TIM_W-1:0]  mul_b;
    logic [DIST_W-1:0] mul_p;
    logic [DIST_W-1:0] n_dist;
    t_rec              rd_rec;
    t_tbl_wr           tbl_wr;
    logic              s_xfer;
    logic              chk_vld;
    logic              id_match;
    logic              kill;
    logic              ins_new;
    logic              out_load;
    logic [DIST_W-1:0] out_dist;

    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // Shared multiplier: neighbor term first, own term second.
    assign mul_a = (r_state == ST_MUL_A) ? r_speed : r_own_speed;
    assign mul_b = (r_state == ST_MUL_A) ? r_now   : r_own_ts;

    ntdp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Absolute difference of the two products.
    assign n_dist = (r_prod_a >= mul_p) ? (r_prod_a - mul_p) : (mul_p - r_prod_a);

    // Slot check on the record read back during the scan.
    assign chk_vld  = r_valid[r_chk_idx];
    assign id_match = (rd_rec.node == r_node);
    assign kill     = (r_state == ST_SCAN) && r_chk && chk_vld &&
                      (((r_func == FN_REMOVE) && id_match) ||
                       ((r_func == FN_PRUNE) && (rd_rec.distance > r_limit)));

    // A hello for an unknown id takes the lowest free slot.
    assign ins_new = (r_func == FN_HELLO) && !r_hit && r_have_free;

    // Record write-back for a hello.
    always_comb begin
        tbl_wr.en            = (r_state == ST_WRITE) && (r_func == FN_HELLO) &&
                               (r_hit || r_have_free);
        tbl_wr.addr          = r_hit ? r_hit_idx : r_free_idx;
        tbl_wr.rec.own_speed = r_own_speed;
        tbl_wr.rec.distance  = r_dist;
        tbl_wr.rec.dst_y     = r_dst_y;
        tbl_wr.rec.dst_x     = r_dst_x;
        tbl_wr.rec.src_y     = r_src_y;
        tbl_wr.rec.src_x     = r_src_x;
        tbl_wr.rec.speed     = r_speed;
        tbl_wr.rec.node      = r_node;
    end

    ntdp_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (r_cnt[TBL_AW-1:0]),
        .o_rd_data (rd_rec)
    );

    // The result enters the output register once that register is free.
    assign out_load = (r_state == ST_DONE) && (!r_m_valid || i_m_axis_tready);
    assign out_dist = (r_func == FN_HELLO) ? r_dist : '0;

    // Sequencer and table control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_removed   <= '0;
            r_cnt       <= '0;
            r_chk       <= 1'b0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            r_m_valid   <= 1'b0;
            r_own_speed <= '0;
            r_own_ts    <= '0;
        end else begin
            // Configuration writes.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OWN_SPEED: r_own_speed <= i_cfg_data[SPD_W-1:0];
                    CFG_OWN_TS:    r_own_ts    <= i_cfg_data[TIM_W-1:0];
                    default:       ;
                endcase
            end

            // Output register handshake.
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_xfer) begin
                        r_state <= ST_MUL_A;
                    end
                end
                ST_MUL_A: begin
                    r_state <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    r_state <= ST_DIST;
                end
                ST_DIST: begin
                    r_state     <= ST_SCAN;
                    r_cnt       <= '0;
                    r_chk       <= 1'b0;
                    r_hit       <= 1'b0;
                    r_have_free <= 1'b0;
                    r_removed   <= '0;
                end
                ST_SCAN: begin
                    // Read slot r_cnt while checking the slot read last cycle.
                    r_chk <= (r_cnt < TBL_N);
                    if (r_cnt < TBL_N) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= ST_WRITE;
                    end
                    if (kill) begin
                        r_valid[r_chk_idx] <= 1'b0;
                        r_count            <= r_count - 1'b1;
                        r_removed          <= r_removed + 1'b1;
                    end
                    if (r_chk && (r_func == FN_HELLO)) begin
                        if (chk_vld && id_match) begin
                            r_hit <= 1'b1;
                        end
                        if (!chk_vld && !r_have_free) begin
                            r_have_free <= 1'b1;
                        end
                    end
                end
                ST_WRITE: begin
                    if (ins_new) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_count             <= r_count + 1'b1;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_func  <= i_s_axis_tuser[1:0];
            r_node  <= i_s_axis_tdata[15:0];
            r_speed <= i_s_axis_tdata[31:16];
            r_src_x <= i_s_axis_tdata[63:32];
            r_src_y <= i_s_axis_tdata[95:64];
            r_dst_x <= i_s_axis_tdata[127:96];
            r_dst_y <= i_s_axis_tdata[159:128];
            r_now   <= i_s_axis_tdata[191:160];
            r_limit <= i_s_axis_tdata[239:192];
        end
        if (r_state == ST_MUL_B) begin
            r_prod_a <= mul_p;
        end
        if (r_state == ST_DIST) begin
            r_dist <= n_dist;
        end
        if (r_state == ST_SCAN) begin
            r_chk_idx <= r_cnt[TBL_AW-1:0];
            if (r_chk && (r_func == FN_HELLO)) begin
                if (chk_vld && id_match) begin
                    r_hit_idx <= r_chk_idx;
                end
                if (!chk_vld && !r_have_free) begin
                    r_free_idx <= r_chk_idx;
                end
            end
        end
        if (r_state == ST_WRITE) begin
            r_found   <= ((r_func == FN_HELLO) && r_hit) ||
                         ((r_func == FN_REMOVE) && (r_removed != '0));
            r_dropped <= (r_func == FN_HELLO) && !r_hit && !r_have_free;
        end
        if (out_load) begin
            r_m_data <= {2'b00, out_dist, cnt_to_out(r_count),
                         cnt_to_out(r_removed), r_dropped, r_found};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ntdp_checker.sv */
// ============================================================================
// ntdp_checker
// Port-level checks on the neighbor table unit, attached by a bind.
// ============================================================================
`default_nettype none

module ntdp_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    input  wire logic                          o_s_axis_tready,
    input  wire logic                          o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    input  wire logic [ntdp_pkg::M_DATA_W-1:0] o_m_axis_tdata
);
    import ntdp_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // One item at a time: no input transfer right after one.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an input transfer");

    // A dropped insert neither found the id nor removed anything.
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |->
        !o_m_axis_tdata[0] && (o_m_axis_tdata[7:2] == '0))
        else $error("dropped result with found or removals");

    // The entry count never exceeds the table size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        (TABLE_ENTRIES > 63) || (int'(o_m_axis_tdata[13:8]) <= TABLE_ENTRIES))
        else $error("entry count above table size");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind neighbor_table_distance_prune_unit ntdp_checker u_ntdp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
